/* rtl/oed_pkg.sv */
// ----------------------------------------------------------------------------
// oed_pkg: shared types and constants for the octal escape decoder
// Character codes, escape phase codes and the state/result structs.
// ----------------------------------------------------------------------------
`default_nettype none

package oed_pkg;

   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam int unsigned OCTAL_DIGIT_BITS = 3;

   // escape phase codes
   localparam logic [1:0] PH_PLAIN = 2'd0;  // plain text
   localparam logic [1:0] PH_ESC   = 2'd1;  // after a backslash
   localparam logic [1:0] PH_ONE   = 2'd2;  // one octal digit seen
   localparam logic [1:0] PH_TWO   = 2'd3;  // two octal digits seen

   typedef struct packed {
      logic [1:0] phase;
      logic [5:0] accum;
      logic       dropping;
   } dec_state_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       error;
   } dec_result_type;

endpackage

`default_nettype wire

/* rtl/oed_step.sv */
// ----------------------------------------------------------------------------
// oed_step: one decode step
// Combinational next state and optional result for one character.
// ----------------------------------------------------------------------------
`default_nettype none

module oed_step
   import oed_pkg::*;
(
   input  wire dec_state_type  state_cur,
   input  wire logic [7:0]     char_cur,
   input  wire logic           last_cur,
   output dec_state_type       state_nxt,
   output logic                emit,
   output dec_result_type      result
);

   logic                           is_octal;
   logic [OCTAL_DIGIT_BITS-1:0]    digit;
   logic                           bad;
   logic                           done;
   logic [7:0]                     value;
   dec_state_type                  step;

   // '0'..'7' are 0x30..0x37
   assign is_octal = (char_cur[7:3] == CH_ZERO[7:3]);
   assign digit    = char_cur[OCTAL_DIGIT_BITS-1:0];

   always_comb begin
      step  = state_cur;
      bad   = 1'b0;
      done  = 1'b0;
      value = char_cur;
      unique case (state_cur.phase)
         PH_PLAIN: begin
            if (char_cur == CH_BACKSLASH) begin
               step.phase = PH_ESC;
            end else begin
               done = 1'b1;
            end
         end
         PH_ESC: begin
            if (char_cur == CH_BACKSLASH) begin
               done       = 1'b1;
               step.phase = PH_PLAIN;
            end else if (is_octal) begin
               step.accum = {3'b000, digit};
               step.phase = PH_ONE;
            end else begin
               bad = 1'b1;
            end
         end
         PH_ONE: begin
            if (is_octal) begin
               step.accum = {state_cur.accum[2:0], digit};
               step.phase = PH_TWO;
            end else begin
               bad = 1'b1;
            end
         end
         PH_TWO: begin
            if (is_octal) begin
               // (accum*8 + d) truncated to 8 bits
               value      = {state_cur.accum[4:0], digit};
               done       = 1'b1;
               step.phase = PH_PLAIN;
               step.accum = 6'd0;
            end else begin
               bad = 1'b1;
            end
         end
         default: begin
            bad = 1'b1;
         end
      endcase

      // escape still open at end of string
      if (last_cur && (step.phase != PH_PLAIN)) begin
         bad = 1'b1;
      end

      state_nxt    = step;
      emit         = 1'b0;
      result.data  = value;
      result.last  = last_cur;
      result.error = 1'b0;

      if (state_cur.dropping) begin
         state_nxt = state_cur;
         if (last_cur) begin
            state_nxt.dropping = 1'b0;
            state_nxt.phase    = PH_PLAIN;
            state_nxt.accum    = 6'd0;
         end
      end else if (bad) begin
         state_nxt.phase    = PH_PLAIN;
         state_nxt.accum    = 6'd0;
         state_nxt.dropping = ~last_cur;
         emit               = 1'b1;
         result.data        = 8'd0;
         result.last        = 1'b1;
         result.error       = 1'b1;
      end else begin
         emit = done;
      end
   end

endmodule

`default_nettype wire

/* rtl/octal_escape_decoder.sv */
// ----------------------------------------------------------------------------
// octal_escape_decoder: backslash/octal escape decoder
// Rebuilds raw bytes from an escaped character stream.
// ----------------------------------------------------------------------------
// One character enters per req transaction and at most one byte leaves per
// rsp transaction. Plain characters pass through, "\\" gives one backslash,
// "\ddd" (octal digits 0-7) gives the byte d1*64+d2*8+d3 mod 256. A bad
// escape, or an escape left open on the last character, produces a single
// rsp transaction with tuser (error) and tlast set and tdata zero; the rest
// of that string is then discarded up to its tlast character. Throughput is
// one character per clock while rsp is not stalled: the decode step is a
// small phase update and a shift of the octal accumulator, done in one pass
// between the input register and the result register. An accepted
// character's result goes from the input register into the result register
// that drives rsp. A result held by rsp_tready low stalls the input register,
// and req_tready drops once that register is also occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module octal_escape_decoder
   import oed_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   // input characters
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,    // [7:0] in_char
   input  wire logic       req_tlast,    // in_last
   // decoded bytes
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,    // [7:0] out_byte
   output logic            rsp_tlast,    // out_last
   output logic            rsp_tuser     // [0] out_error
);

   // input register
   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_char_ff;
   logic           in_last_ff;

   // decoder state, updated when the input register's item is consumed
   dec_state_type  state_ff, state_in;

   // result register
   logic           out_valid_ff, out_valid_in;
   dec_result_type out_ff;

   // step outputs
   logic           step_emit;
   dec_result_type step_result;

   logic           advance;     // input-register item consumed this cycle
   logic           out_free;    // result register can take a new value

   oed_step u_step (
      .state_cur (state_ff),
      .char_cur  (in_char_ff),
      .last_cur  (in_last_ff),
      .state_nxt (state_in),
      .emit      (step_emit),
      .result    (step_result)
   );

   // The result register frees up when empty or when its transaction
   // completes this cycle; a stalled result holds the input register.
   assign out_free   = ~out_valid_ff | rsp_tready;
   assign advance    = in_valid_ff & out_free;
   assign req_tready = ~in_valid_ff | advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = advance & step_emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         state_ff.phase <= PH_PLAIN;
         state_ff.accum <= 6'd0;
         state_ff.dropping <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance && step_emit && out_free) begin
         out_ff <= step_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff.data;
   assign rsp_tlast  = out_ff.last;
   assign rsp_tuser  = out_ff.error;

endmodule

`default_nettype wire

/* dv/tb_octal_escape_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_octal_escape_decoder: self-checking bench for the octal escape decoder
// Drives escaped character strings on req, predicts the decoded bytes and
// error marks per accepted transaction, and checks every rsp transaction in
// order. Both sides idle at random, with one long stretch at full rate.
// ----------------------------------------------------------------------------

module tb_octal_escape_decoder;
   import oed_pkg::*;

   // -------------------------------------------------------------------------
   // Decoded-byte scoreboard: tracks the escape state the block should be in
   // and keeps the bytes it owes us, oldest first.
   // -------------------------------------------------------------------------
   class byte_scoreboard;
      logic [1:0]     phase;
      logic [5:0]     accum;
      logic           dropping;
      dec_result_type owed_q[$];
      int unsigned    mismatches;

      function new();
         phase      = PH_PLAIN;
         accum      = '0;
         dropping   = 1'b0;
         mismatches = 0;
      endfunction

      function int unsigned pending();
         return owed_q.size();
      endfunction

      // one accepted character: advance the escape state, queue any byte due
      function void note_char(logic [7:0] c, logic l);
         logic       bad;
         logic       done;
         logic       is_oct;
         logic [7:0] value;
         logic [7:0] digit;
         bad    = 1'b0;
         done   = 1'b0;
         value  = '0;
         digit  = c - CH_ZERO;
         is_oct = (c >= CH_ZERO) && (c <= CH_ZERO + 8'd7);

         // after an error everything up to tlast is swallowed
         if (dropping) begin
            if (l) begin
               dropping = 1'b0;
               phase    = PH_PLAIN;
               accum    = '0;
            end
            return;
         end

         case (phase)
            PH_PLAIN: begin
               if (c == CH_BACKSLASH) phase = PH_ESC;
               else begin
                  value = c;
                  done  = 1'b1;
               end
            end
            PH_ESC: begin
               if (c == CH_BACKSLASH) begin
                  value = CH_BACKSLASH;
                  done  = 1'b1;
                  phase = PH_PLAIN;
               end else if (is_oct) begin
                  accum = {3'b000, digit[2:0]};
                  phase = PH_ONE;
               end else bad = 1'b1;
            end
            PH_ONE: begin
               if (is_oct) begin
                  accum = {accum[2:0], digit[2:0]};
                  phase = PH_TWO;
               end else bad = 1'b1;
            end
            default: begin
               // third digit: top bit of d1 falls off the 8-bit byte
               if (is_oct) begin
                  value = {accum[4:0], digit[2:0]};
                  done  = 1'b1;
                  phase = PH_PLAIN;
                  accum = '0;
               end else bad = 1'b1;
            end
         endcase

         // escape still open on the final character
         if (!bad && l && phase != PH_PLAIN) bad = 1'b1;

         if (bad) begin
            phase    = PH_PLAIN;
            accum    = '0;
            dropping = !l;
            owed_q.push_back(dec_result_type'{data: 8'h00, last: 1'b1, error: 1'b1});
         end else if (done) begin
            owed_q.push_back(dec_result_type'{data: value, last: l, error: 1'b0});
         end
      endfunction

      // one accepted rsp transaction against the oldest owed byte
      function void check_byte(logic [7:0] data, logic l, logic err);
         dec_result_type want;
         if (owed_q.size() == 0) begin
            $display("%0t: unexpected rsp data=%h last=%b error=%b", $time, data, l, err);
            mismatches++;
            return;
         end
         want = owed_q.pop_front();
         if (data !== want.data) begin
            $display("%0t: tdata expected %h actual %h", $time, want.data, data);
            mismatches++;
         end
         if (l !== want.last) begin
            $display("%0t: tlast expected %b actual %b", $time, want.last, l);
            mismatches++;
         end
         if (err !== want.error) begin
            $display("%0t: tuser expected %b actual %b", $time, want.error, err);
            mismatches++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block ports. Every input has a known value at time 0.
   // -------------------------------------------------------------------------
   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // [7:0] in_char
   logic       req_tlast  = 1'b0;    // in_last
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [7:0] out_byte
   logic       rsp_tlast;            // out_last
   logic       rsp_tuser;            // [0] out_error

   byte_scoreboard sb = new();

   // chance in percent that either side sits out a cycle; zeroed for a stretch
   int unsigned idle_pct     = 11;
   int unsigned random_chars = 0;

   octal_escape_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #200000;
      $display("octal_escape_decoder: mismatch");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Sender side. Signals are sampled right after the edge, so they hold the
   // values the block saw at that edge; the next drive is one NBA per signal.
   // -------------------------------------------------------------------------
   task automatic send_char(input logic [7:0] c, input logic l);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= l;
      do @(posedge clock); while (!req_tready);
      sb.note_char(c, l);
   endtask

   // a whole string, tlast on its final character
   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
   endtask

   function automatic logic [7:0] octal_digit();
      return CH_ZERO + 8'($urandom_range(0, 7));
   endfunction

   // any byte except the backslash, so it stays a plain character
   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      return (c == CH_BACKSLASH) ? 8'h5D : c;
   endfunction

   // Random string: mostly well-formed pieces (plain bytes, escaped
   // backslashes, octal escapes), with some bad or cut-off escapes mixed in.
   // One string in ten is raw noise, backslashes and all.
   task automatic send_random_string();
      logic [7:0] text_q[$];
      int unsigned pieces;
      int unsigned kind;
      int unsigned ndig;
      pieces = $urandom_range(1, 8);
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat (pieces) begin
            kind = $urandom_range(0, 99);
            if (kind < 50) text_q.push_back(plain_char());
            else if (kind < 62) begin
               text_q.push_back(CH_BACKSLASH);
               text_q.push_back(CH_BACKSLASH);
            end else if (kind < 90) begin
               text_q.push_back(CH_BACKSLASH);
               repeat (3) text_q.push_back(octal_digit());
            end else if (kind < 95) begin
               // bad escape, leaning on '8' and '9'
               text_q.push_back(CH_BACKSLASH);
               ndig = $urandom_range(0, 2);
               repeat (ndig) text_q.push_back(octal_digit());
               if ($urandom_range(0, 1)) text_q.push_back(CH_ZERO + 8'($urandom_range(8, 9)));
               else text_q.push_back(8'($urandom_range(0, 255)));
            end else begin
               // escape cut short; whether it errors depends on what follows, and it always does if it ends the string
               text_q.push_back(CH_BACKSLASH);
               ndig = $urandom_range(0, 2);
               repeat (ndig) text_q.push_back(octal_digit());
            end
         end
      end
      foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
      random_chars += text_q.size();
   endtask

   // -------------------------------------------------------------------------
   // Receiver side: random stalls on rsp_tready, every transaction checked.
   // -------------------------------------------------------------------------
   initial begin
      @(negedge reset);
      forever begin
         rsp_tready <= ($urandom_range(0, 99) >= idle_pct);
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) sb.check_byte(rsp_tdata, rsp_tlast, rsp_tuser);
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero and all-ones pass through like any other character
      send_char(8'h00, 1'b0);
      send_char(8'hFF, 1'b0);
      send_char("A", 1'b1);
      // doubled backslash
      send_text("\\\\");
      // truncation of the top octal bit: 777 -> FF, 400 -> 00
      send_text("\\777\\400");
      // '8' is no octal digit; the rest, a backslash here, is dropped
      send_text("\\8\\");
      // '9' right on the final character
      send_text("\\9");
      // escapes left open at the end of the string
      send_text("\\1");
      send_text("\\");
      // bad third digit on the final character
      send_text("\\12x");

      // random strings, with a long full-rate stretch in the middle
      while (random_chars < 1350) begin
         idle_pct = (random_chars >= 500 && random_chars < 850) ? 0 : 11;
         send_random_string();
      end
      req_tvalid <= 1'b0;
      idle_pct = 11;

      // drain, then give the pipeline time to show any extra byte
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (sb.mismatches == 0) $display("octal_escape_decoder: match");
      else $display("octal_escape_decoder: mismatch");
      $finish;
   end

endmodule
